### rtl/core/wsfp_pkg.sv
// Package for the frame parser: parse phases, status codes, result item
// layout and the helpers that build result items. No dependencies.
package wsfp_pkg;

  localparam logic [7:0] BYTE_HIGH_BIT = 8'h80;
  localparam logic [7:0] BYTE_FF       = 8'hFF;
  localparam logic [7:0] BYTE_00       = 8'h00;
  localparam logic [7:0] LEN_EXT16     = 8'h7E;
  localparam logic [7:0] LEN_EXT64     = 8'h7F;
  localparam logic [7:0] LEN_MAX_SHORT = 8'h7D;

  localparam logic [3:0] HDR_BYTES_16 = 4'd2;
  localparam logic [3:0] HDR_BYTES_64 = 4'd8;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned OUT_TDATA_W = 80;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TEXT,
    PH_SECOND,
    PH_HEADER,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [2:0] {
    ST_TEXT       = 3'd0,
    ST_BINARY     = 3'd1,
    ST_CLOSING    = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_ERROR      = 3'd4
  } status_e;

  // item_kind doubles as last: only the status item closes a run
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [63:0] payload_length;
  } result_t;

  typedef struct packed {
    logic    r0_valid;
    logic    r1_valid;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic result_t mk_payload(logic [7:0] b);
    result_t r;
    r.item_kind      = 1'b0;
    r.payload_byte   = b;
    r.frame_status   = ST_TEXT;
    r.payload_length = 64'd0;
    return r;
  endfunction

  function automatic result_t mk_status(status_e st, logic [63:0] len);
    result_t r;
    r.item_kind      = 1'b1;
    r.payload_byte   = 8'd0;
    r.frame_status   = st;
    r.payload_length = len;
    return r;
  endfunction

endpackage

### rtl/core/wsfp_parser.sv
// Frame parser state machine: takes one registered byte per step and
// produces up to two result items. Depends on wsfp_pkg.
module wsfp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     data_byte_i,
  input  logic           buffer_end_i,
  output wsfp_pkg::push_t push_o
);
  import wsfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic        first_ff_q, first_ff_d;
  logic [3:0]  hdr_left_q, hdr_left_d;
  logic [63:0] len_q, len_d;
  logic [63:0] remain_q, remain_d;
  logic [63:0] count_q, count_d;
  logic        done_q, done_d;

  logic [3:0]  hdr_dec;
  logic [63:0] hdr_len;
  logic [63:0] sec_len;
  logic [63:0] begin_len;
  logic        is_short_len;
  logic        is_ext_len;
  logic        is_close;
  logic        status_now;
  logic        begin_ok;

  assign hdr_dec      = (hdr_left_q != 4'd0) ? hdr_left_q - 4'd1 : 4'd0;
  assign hdr_len      = {len_q[55:0], data_byte_i};
  assign sec_len      = {56'd0, data_byte_i};
  assign begin_len    = (phase_q == PH_SECOND) ? sec_len : hdr_len;
  assign is_short_len = (data_byte_i <= LEN_MAX_SHORT);
  assign is_ext_len   = (data_byte_i == LEN_EXT16) || (data_byte_i == LEN_EXT64);
  assign is_close     = first_ff_q && (data_byte_i == BYTE_00);
  // header done with nonzero length and buffer continues: payload follows
  assign begin_ok     = (begin_len != 64'd0) && !buffer_end_i;

  // result items
  always_comb begin
    push_o          = '0;
    push_o.r0       = mk_payload(data_byte_i);
    push_o.r1       = mk_status(ST_BINARY, len_q);
    if (step_i && !done_q) begin
      case (phase_q)
        PH_TEXT: begin
          push_o.r0_valid = 1'b1;
          if (data_byte_i == BYTE_FF) begin
            push_o.r0 = mk_status(ST_TEXT, count_q);
          end else if (buffer_end_i) begin
            push_o.r0 = mk_status(ST_INCOMPLETE, 64'd0);
          end
        end
        PH_SECOND: begin
          if (is_close) begin
            push_o.r0_valid = 1'b1;
            push_o.r0       = mk_status(ST_CLOSING, 64'd0);
          end else if (is_short_len) begin
            push_o.r0_valid = !begin_ok;
            push_o.r0       = (begin_len == 64'd0) ? mk_status(ST_BINARY, 64'd0)
                                                    : mk_status(ST_ERROR, 64'd0);
          end else if (is_ext_len) begin
            push_o.r0_valid = buffer_end_i;
            push_o.r0       = mk_status(ST_ERROR, 64'd0);
          end else begin
            push_o.r0_valid = 1'b1;
            push_o.r0       = mk_status(ST_ERROR, 64'd0);
          end
        end
        PH_HEADER: begin
          if (hdr_dec == 4'd0) begin
            push_o.r0_valid = !begin_ok;
            push_o.r0       = (begin_len == 64'd0) ? mk_status(ST_BINARY, 64'd0)
                                                    : mk_status(ST_ERROR, 64'd0);
          end else begin
            push_o.r0_valid = buffer_end_i;
            push_o.r0       = mk_status(ST_ERROR, 64'd0);
          end
        end
        PH_PAYLOAD: begin
          push_o.r0_valid = 1'b1;
          if (remain_q <= 64'd1) begin
            push_o.r1_valid = 1'b1;
          end else if (buffer_end_i) begin
            push_o.r0 = mk_status(ST_ERROR, 64'd0);
          end
        end
        default: begin
          push_o.r0_valid = buffer_end_i;
          push_o.r0       = mk_status(ST_INCOMPLETE, 64'd0);
        end
      endcase
    end
  end

  assign status_now = (push_o.r0_valid && push_o.r0.item_kind) || push_o.r1_valid;

  // next state
  always_comb begin
    phase_d    = phase_q;
    first_ff_d = first_ff_q;
    hdr_left_d = hdr_left_q;
    len_d      = len_q;
    remain_d   = remain_q;
    count_d    = count_q;
    done_d     = done_q;
    if (step_i && !done_q) begin
      case (phase_q)
        PH_TEXT: begin
          if (data_byte_i != BYTE_FF && !buffer_end_i) begin
            count_d = count_q + 64'd1;
          end
        end
        PH_SECOND: begin
          if (!is_close && is_short_len) begin
            len_d = sec_len;
            if (begin_ok) begin
              remain_d = sec_len;
              count_d  = 64'd0;
              phase_d  = PH_PAYLOAD;
            end
          end else if (!is_close && is_ext_len) begin
            hdr_left_d = (data_byte_i == LEN_EXT16) ? HDR_BYTES_16 : HDR_BYTES_64;
            len_d      = 64'd0;
            phase_d    = PH_HEADER;
          end
        end
        PH_HEADER: begin
          len_d      = hdr_len;
          hdr_left_d = hdr_dec;
          if (hdr_dec == 4'd0 && begin_ok) begin
            remain_d = hdr_len;
            count_d  = 64'd0;
            phase_d  = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (remain_q <= 64'd1) begin
            count_d  = count_q + 64'd1;
            remain_d = 64'd0;
          end else if (!buffer_end_i) begin
            count_d  = count_q + 64'd1;
            remain_d = remain_q - 64'd1;
          end
        end
        default: begin
          count_d    = 64'd0;
          first_ff_d = (data_byte_i == BYTE_FF);
          phase_d    = ((data_byte_i & BYTE_HIGH_BIT) != BYTE_00) ? PH_SECOND : PH_TEXT;
        end
      endcase
      if (status_now) begin
        done_d = 1'b1;
      end
    end
    // buffer end returns everything to idle
    if (step_i && buffer_end_i) begin
      phase_d    = PH_IDLE;
      first_ff_d = 1'b0;
      hdr_left_d = 4'd0;
      len_d      = 64'd0;
      remain_d   = 64'd0;
      count_d    = 64'd0;
      done_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      first_ff_q <= 1'b0;
      hdr_left_q <= 4'd0;
      len_q      <= 64'd0;
      remain_q   <= 64'd0;
      count_q    <= 64'd0;
      done_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      first_ff_q <= first_ff_d;
      hdr_left_q <= hdr_left_d;
      len_q      <= len_d;
      remain_q   <= remain_d;
      count_q    <= count_d;
      done_q     <= done_d;
    end
  end

endmodule

### rtl/core/wsfp_fifo.sv
// Result queue: takes up to two items per cycle from the parser and
// hands one per transfer to the output stream. Depends on wsfp_pkg.
module wsfp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wsfp_pkg::push_t   push_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output wsfp_pkg::result_t head_o
);
  import wsfp_pkg::*;

  result_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [CNT_W-1:0] n_push;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign pop       = valid_o && ready_i;
  assign n_push    = CNT_W'(push_i.r0_valid) + CNT_W'(push_i.r1_valid);
  assign wr_ptr_p1 = wr_ptr_q + PTR_W'(1);
  // two free slots so a step may always push both results
  assign room_o    = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
  assign valid_o   = (cnt_q != '0);
  assign head_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    cnt_d    = cnt_q + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.r0_valid) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.r1_valid) begin
      mem_q[wr_ptr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/core/websocket_frame_parser_top.sv
// Channel   Dir  tdata (low bit up)                       tlast       tuser
// s_axis    in   data_byte[7:0]                           buffer_end  -
// m_axis    out  payload_byte, frame_status, length, pad  last        item_kind
//
// One byte per cycle while the result queue has room. A byte is registered at
// the input, then goes through the parser into a four-entry result queue. The
// last payload byte of a binary frame queues two results; the queue keeps two
// slots free before a byte is parsed.
// Reset is asynchronous, active low, and returns the parser to idle.
// Depends on wsfp_pkg, wsfp_parser, wsfp_fifo.
module websocket_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte[7:0]
  input  logic        s_axis_tlast_i,   // buffer_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [wsfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
                        // payload_byte[7:0], frame_status[10:8],
                        // payload_length[74:11], zero[79:75]
  output logic        m_axis_tlast_o,   // last
  output logic        m_axis_tuser_o    // item_kind
);
  import wsfp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       room;
  logic       step;
  logic       in_xfer;
  push_t      push;
  result_t    head;

  assign step            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = in_xfer || (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tlast_i;
    end
  end

  wsfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (in_byte_q),
    .buffer_end_i (in_end_q),
    .push_o       (push)
  );

  wsfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {5'd0, head.payload_length, head.frame_status, head.payload_byte};
  assign m_axis_tlast_o = head.item_kind;
  assign m_axis_tuser_o = head.item_kind;

endmodule

### bench/wsfp_frame_checker.sv
// Frame checker for the websocket frame parser: tracks every byte transfer
// on s_axis, predicts the parser's result items and compares m_axis transfers.
// Depends on wsfp_pkg.
`timescale 1ns / 100ps

module wsfp_frame_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  input  logic [7:0]                       s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  input  logic [wsfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                             m_axis_tlast_i,
  input  logic                             m_axis_tuser_i,
  output int                               fail_cnt_o,
  output int                               pending_o
);
  import wsfp_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pbyte;
    logic [2:0]  status;
    logic [63:0] plen;
    logic        last;
  } frame_item_t;

  frame_item_t parsed_items_q [$];

  // parser state as seen from outside
  phase_e      phase;
  logic        first_ff;
  logic [3:0]  hdr_left;
  logic [63:0] len_acc;
  logic [63:0] remaining;
  logic [63:0] byte_cnt;
  logic        done;

  function automatic void clear_state();
    phase     = PH_IDLE;
    first_ff  = 1'b0;
    hdr_left  = 4'd0;
    len_acc   = 64'd0;
    remaining = 64'd0;
    byte_cnt  = 64'd0;
    done      = 1'b0;
  endfunction

  function automatic void queue_payload(logic [7:0] b);
    frame_item_t it;
    it.kind   = 1'b0;
    it.pbyte  = b;
    it.status = ST_TEXT;
    it.plen   = 64'd0;
    it.last   = 1'b0;
    parsed_items_q.push_back(it);
  endfunction

  function automatic void queue_status(status_e st, logic [63:0] len);
    frame_item_t it;
    it.kind   = 1'b1;
    it.pbyte  = 8'd0;
    it.status = st;
    it.plen   = len;
    it.last   = 1'b1;
    parsed_items_q.push_back(it);
  endfunction

  // Length known: returns 1 when the frame ends right here.
  function automatic logic header_done(logic eob);
    if (len_acc == 64'd0) begin
      queue_status(ST_BINARY, 64'd0);
      return 1'b1;
    end
    if (eob) begin
      queue_status(ST_ERROR, 64'd0);
      return 1'b1;
    end
    remaining = len_acc;
    byte_cnt  = 64'd0;
    phase     = PH_PAYLOAD;
    return 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eob);
    logic ended;
    ended = 1'b0;
    // frame already reported: swallow up to the buffer end
    if (done) begin
      if (eob) clear_state();
      return;
    end
    case (phase)
      PH_TEXT: begin
        if (b == BYTE_FF) begin
          queue_status(ST_TEXT, byte_cnt);
          ended = 1'b1;
        end else if (eob) begin
          queue_status(ST_INCOMPLETE, 64'd0);
          ended = 1'b1;
        end else begin
          queue_payload(b);
          byte_cnt = byte_cnt + 64'd1;
        end
      end
      PH_SECOND: begin
        if (first_ff && b == BYTE_00) begin
          queue_status(ST_CLOSING, 64'd0);
          ended = 1'b1;
        end else if (b <= LEN_MAX_SHORT) begin
          len_acc = {56'd0, b};
          ended   = header_done(eob);
        end else if (b == LEN_EXT16 || b == LEN_EXT64) begin
          hdr_left = (b == LEN_EXT16) ? HDR_BYTES_16 : HDR_BYTES_64;
          len_acc  = 64'd0;
          phase    = PH_HEADER;
          if (eob) begin
            queue_status(ST_ERROR, 64'd0);
            ended = 1'b1;
          end
        end else begin
          queue_status(ST_ERROR, 64'd0);
          ended = 1'b1;
        end
      end
      PH_HEADER: begin
        len_acc = {len_acc[55:0], b};
        if (hdr_left != 4'd0) hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          ended = header_done(eob);
        end else if (eob) begin
          queue_status(ST_ERROR, 64'd0);
          ended = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (remaining <= 64'd1) begin
          queue_payload(b);
          byte_cnt  = byte_cnt + 64'd1;
          remaining = 64'd0;
          queue_status(ST_BINARY, len_acc);
          ended = 1'b1;
        end else if (eob) begin
          queue_status(ST_ERROR, 64'd0);
          ended = 1'b1;
        end else begin
          queue_payload(b);
          byte_cnt  = byte_cnt + 64'd1;
          remaining = remaining - 64'd1;
        end
      end
      default: begin
        byte_cnt = 64'd0;
        if ((b & BYTE_HIGH_BIT) != 8'd0) begin
          first_ff = (b == BYTE_FF);
          phase    = PH_SECOND;
        end else begin
          first_ff = 1'b0;
          phase    = PH_TEXT;
        end
        if (eob) begin
          queue_status(ST_INCOMPLETE, 64'd0);
          ended = 1'b1;
        end
      end
    endcase
    if (eob) clear_state();
    else if (ended) done = 1'b1;
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    frame_item_t want;
    if (!rst_ni) begin
      clear_state();
      parsed_items_q.delete();
      fail_cnt_o = 0;
    end else begin
      // results reach the outputs through registers, so compare before predicting
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (parsed_items_q.size() == 0) begin
          $error("result transfer with nothing expected: tdata %0h", m_axis_tdata_i);
          fail_cnt_o++;
        end else begin
          want = parsed_items_q.pop_front();
          check_field("item_kind", 64'(want.kind), 64'(m_axis_tuser_i));
          check_field("payload_byte", 64'(want.pbyte), 64'(m_axis_tdata_i[7:0]));
          check_field("frame_status", 64'(want.status), 64'(m_axis_tdata_i[10:8]));
          check_field("payload_length", want.plen, m_axis_tdata_i[74:11]);
          check_field("tdata padding", 64'd0, 64'(m_axis_tdata_i[79:75]));
          check_field("last", 64'(want.last), 64'(m_axis_tlast_i));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) parse_byte(s_axis_tdata_i, s_axis_tlast_i);
    end
    pending_o = parsed_items_q.size();
  end

endmodule

### bench/websocket_frame_parser_top_tb.sv
// Testbench top for websocket_frame_parser_top: drives receive buffers byte by
// byte with random flow control and gives the verdict. Depends on wsfp_pkg and
// wsfp_frame_checker, which does the prediction and comparison.
`timescale 1ns / 100ps

module websocket_frame_parser_top_tb;
  import wsfp_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 750;
  localparam int MODE1_AT     = 280;
  localparam int MODE2_AT     = 530;
  localparam int BACKLOG_AT   = 600;
  localparam int BACKLOG_LEN  = 60;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;

  int fail_cnt;
  int pending;
  int sent_bytes = 0;
  int quiet_cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;
  logic backlog_done = 1'b0;

  logic [7:0] frame_bytes_q [$];

  // bit 8 marks the buffer's last byte
  logic [8:0] directed_bytes [$] = '{
    9'h141,                                 // one-byte buffer
    9'h000, 9'h080, 9'h0FF, 9'h112,         // text, trailing byte swallowed
    9'h0FF, 9'h100,                         // closing
    9'h081, 9'h080, 9'h155,                 // bad length byte
    9'h082, 9'h100,                         // zero-length binary
    9'h082, 9'h07E, 9'h101,                 // header cut short
    9'h082, 9'h002, 9'h1AA,                 // payload cut short
    9'h07F, 9'h101,                         // text with no terminator
    9'h0FF, 9'h07F, 9'h000, 9'h000, 9'h000, // 64-bit length of one
    9'h000, 9'h000, 9'h000, 9'h000, 9'h001, 9'h15A
  };

  always #1 clk_i = ~clk_i;

  // sender idles lightly first, then heavily, then not at all
  assign send_idle_pct = (sent_bytes < MODE1_AT) ? 6 : (sent_bytes < MODE2_AT) ? 70 : 0;
  assign recv_idle_pct = (sent_bytes < MODE1_AT) ? 70 : (sent_bytes < MODE2_AT) ? 6 : 0;

  websocket_frame_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  wsfp_frame_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .m_axis_tuser_i  (m_axis_tuser),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending)
  );

  function automatic logic [7:0] rand_byte(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_bytes++;
  endtask

  // One receive buffer: mostly well-formed frames with random content,
  // some cut short, some noise.
  task automatic build_buffer();
    int kind;
    int n;
    int cut;
    frame_bytes_q.delete();
    kind = $urandom_range(99);
    if (kind < 25) begin
      frame_bytes_q.push_back(rand_byte(0, 127));
      n = $urandom_range(6);
      repeat (n) frame_bytes_q.push_back(rand_byte(0, 254));
      if ($urandom_range(7) != 0) frame_bytes_q.push_back(BYTE_FF);
    end else if (kind < 35) begin
      frame_bytes_q.push_back(BYTE_FF);
      frame_bytes_q.push_back(BYTE_00);
    end else if (kind < 60) begin
      frame_bytes_q.push_back(rand_byte(128, 255));
      n = ($urandom_range(9) == 0) ? $urandom_range(int'(LEN_MAX_SHORT)) : $urandom_range(8);
      frame_bytes_q.push_back(8'(n));
      repeat (n) frame_bytes_q.push_back(rand_byte(0, 255));
    end else if (kind < 72) begin
      frame_bytes_q.push_back(rand_byte(128, 255));
      frame_bytes_q.push_back(LEN_EXT16);
      if ($urandom_range(4) == 0) begin
        // long length, buffer ends inside the payload
        frame_bytes_q.push_back(rand_byte(1, 255));
        frame_bytes_q.push_back(rand_byte(0, 255));
        repeat ($urandom_range(3)) frame_bytes_q.push_back(rand_byte(0, 255));
      end else begin
        n = $urandom_range(10);
        frame_bytes_q.push_back(8'd0);
        frame_bytes_q.push_back(8'(n));
        repeat (n) frame_bytes_q.push_back(rand_byte(0, 255));
      end
    end else if (kind < 82) begin
      frame_bytes_q.push_back(rand_byte(128, 255));
      frame_bytes_q.push_back(LEN_EXT64);
      if ($urandom_range(4) == 0) begin
        repeat (8) frame_bytes_q.push_back(rand_byte(0, 255));
        repeat ($urandom_range(3)) frame_bytes_q.push_back(rand_byte(0, 255));
      end else begin
        n = $urandom_range(10);
        repeat (7) frame_bytes_q.push_back(8'd0);
        frame_bytes_q.push_back(8'(n));
        repeat (n) frame_bytes_q.push_back(rand_byte(0, 255));
      end
    end else if (kind < 90) begin
      frame_bytes_q.push_back(rand_byte(128, 255));
      frame_bytes_q.push_back(rand_byte(128, 255));
    end else begin
      repeat ($urandom_range(6, 1)) frame_bytes_q.push_back(rand_byte(0, 255));
    end
    if ($urandom_range(9) < 3) begin
      repeat ($urandom_range(2, 1)) frame_bytes_q.push_back(rand_byte(0, 255));
    end
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(frame_bytes_q.size(), 1);
      while (frame_bytes_q.size() > cut) void'(frame_bytes_q.pop_back());
    end
  endtask

  initial begin
    int i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < directed_bytes.size(); i++) begin
      send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
    end
    while (sent_bytes < directed_bytes.size() + RANDOM_BYTES) begin
      build_buffer();
      for (i = 0; i < frame_bytes_q.size(); i++) begin
        send_byte(frame_bytes_q[i], i == frame_bytes_q.size() - 1);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending != 0) $error("%0d results never arrived", pending);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver; once, holds off long enough for the result queue to fill
  // while the sender keeps offering.
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!backlog_done && sent_bytes >= BACKLOG_AT) begin
        m_axis_tready <= 1'b0;
        repeat (BACKLOG_LEN) @(negedge clk_i);
        backlog_done = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
